/* rtl/core/date_to_day_number_defines.svh */
// ----------------------------------------------------------------------------
// date_to_day_number_defines.svh
// Assertion macros shared by the date to day number RTL.
// ----------------------------------------------------------------------------
`ifndef DATE_TO_DAY_NUMBER_DEFINES_SVH
`define DATE_TO_DAY_NUMBER_DEFINES_SVH

// Check that a condition implies a consequence on the same clock edge.
`define DTDN_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an expression holds on every clock edge out of reset.
`define DTDN_ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`endif

/* rtl/core/dtdn_pkg.sv */
// ----------------------------------------------------------------------------
// dtdn_pkg
// Widths, calendar tables and helpers shared by the date to day number block.
// ----------------------------------------------------------------------------
package dtdn_pkg;

    // Supported span of years
    localparam int FIRST_YEAR = 1900;
    localparam int YEAR_SPAN  = 256;
    localparam int LAST_YEAR  = FIRST_YEAR + YEAR_SPAN - 1;

    // Field widths
    localparam int C_DAY_W   = 5;
    localparam int C_MONTH_W = 4;
    localparam int C_YEAR_W  = 12;
    localparam int C_ADD_W   = 16;
    localparam int C_DNUM_W  = 17;
    localparam int C_WDAY_W  = 3;
    localparam int C_SUM_W   = C_DNUM_W + 1;
    localparam int C_DOY_W   = 9;

    // Year offset and year table index widths
    localparam int C_OFS_W  = (YEAR_SPAN > 1) ? $clog2(YEAR_SPAN) : 1;
    localparam int C_YS_N   = YEAR_SPAN + 1;
    localparam int C_YIDX_W = $clog2(C_YS_N);

    // Calendar constants
    localparam int C_DAYS_PER_YEAR = 365;
    localparam int C_FEB           = 2;
    localparam int C_DEC           = 12;
    localparam int C_Y_MOD4        = FIRST_YEAR % 4;
    localparam int C_Y_MOD100      = FIRST_YEAR % 100;
    localparam int C_Y_MOD400      = FIRST_YEAR % 400;

    // Reciprocals: x / 7 for 16-bit x, x / 366 for 17-bit x
    localparam int C_INV7_SH   = 19;
    localparam int C_INV7      = (2 ** C_INV7_SH + 6) / 7;
    localparam int C_INV366_SH = 25;
    localparam int C_INV366    = (2 ** C_INV366_SH + 365) / 366;

    typedef logic [C_YS_N-1:0]                t_leap_tab;
    typedef logic [C_YS_N-1:0][C_DNUM_W-1:0]  t_year_tab;
    typedef logic [C_YS_N-1:0][C_WDAY_W-1:0]  t_mod7_tab;

    // Month length, start day within the year and start mod 7 (non-leap)
    localparam logic [C_DAY_W-1:0] C_MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };
    localparam logic [C_DOY_W-1:0] C_MONTH_START [16] = '{
        9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
    };
    localparam logic [C_WDAY_W-1:0] C_MONTH_MOD7 [16] = '{
        3'd0, 3'd0, 3'd3, 3'd3, 3'd6, 3'd1, 3'd4, 3'd6,
        3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd0, 3'd0, 3'd0
    };

    // Leap flag per year offset, built with running cycle counters
    function automatic t_leap_tab f_leap_tab();
        t_leap_tab tab;
        int        c4;
        int        c100;
        int        c400;
        c4   = C_Y_MOD4;
        c100 = C_Y_MOD100;
        c400 = C_Y_MOD400;
        for (int i = 0; i < C_YS_N; i++) begin
            tab[i] = ((c4 == 0) && (c100 != 0)) || (c400 == 0);
            c4     = (c4 == 3) ? 0 : c4 + 1;
            c100   = (c100 == 99) ? 0 : c100 + 1;
            c400   = (c400 == 399) ? 0 : c400 + 1;
        end
        return tab;
    endfunction

    localparam t_leap_tab C_LEAP = f_leap_tab();

    // Days from 1 Jan FIRST_YEAR to 1 Jan of each year in the span
    function automatic t_year_tab f_year_start();
        t_year_tab tab;
        int        acc;
        acc = 0;
        for (int i = 0; i < C_YS_N; i++) begin
            tab[i] = C_DNUM_W'(acc);
            acc    = acc + C_DAYS_PER_YEAR + (C_LEAP[i] ? 1 : 0);
        end
        return tab;
    endfunction

    // Same year starts taken mod 7
    function automatic t_mod7_tab f_year_mod7();
        t_mod7_tab tab;
        int        m7;
        m7 = 0;
        for (int i = 0; i < C_YS_N; i++) begin
            tab[i] = C_WDAY_W'(m7);
            m7     = m7 + 1 + (C_LEAP[i] ? 1 : 0);
            if (m7 >= 7) begin
                m7 = m7 - 7;
            end
        end
        return tab;
    endfunction

    localparam t_year_tab             C_YEAR_START  = f_year_start();
    localparam t_mod7_tab             C_YEAR_MOD7   = f_year_mod7();
    localparam logic [C_DNUM_W-1:0]   C_LAST_SERIAL = C_YEAR_START[YEAR_SPAN];

    // x mod 7 for x below 64: quotient by multiply with 37/256
    function automatic logic [C_WDAY_W-1:0] f_mod7_small(input logic [5:0] x);
        logic [11:0] prod;
        logic [3:0]  quo;
        logic [5:0]  rem;
        prod = 12'(x) * 12'd37;
        quo  = prod[11:8];
        rem  = x - 6'(6'(quo) * 6'd7);
        return rem[C_WDAY_W-1:0];
    endfunction

    // Forward results handed to the reverse conversion
    typedef struct packed {
        logic                date_valid;
        logic [C_DNUM_W-1:0] day_number;
        logic [C_WDAY_W-1:0] weekday;
        logic [C_WDAY_W-1:0] new_weekday;
        logic                out_of_range;
        logic [C_DNUM_W-1:0] rel_day;
    } t_rev_info;

    // Complete result item
    typedef struct packed {
        logic                 date_valid;
        logic [C_DNUM_W-1:0]  day_number;
        logic [C_WDAY_W-1:0]  weekday;
        logic [C_DAY_W-1:0]   new_day;
        logic [C_MONTH_W-1:0] new_month;
        logic [C_YEAR_W-1:0]  new_year;
        logic [C_WDAY_W-1:0]  new_weekday;
        logic                 out_of_range;
    } t_result;

endpackage

/* rtl/core/dtdn_day_to_date.sv */
// ----------------------------------------------------------------------------
// dtdn_day_to_date
// Three-stage conversion of a day offset back to year, month and day.
// ----------------------------------------------------------------------------
module dtdn_day_to_date (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  dtdn_pkg::t_rev_info   i_info,
    output logic                  o_vld,
    output dtdn_pkg::t_result     o_res
);
    import dtdn_pkg::*;

    localparam int C_PROD_W = 2 * C_DNUM_W;

    logic                  r4_vld;
    t_rev_info             r4_info;
    logic [C_OFS_W-1:0]    r4_ofs;
    logic [C_PROD_W-1:0]   n4_prod;

    logic                  r5_vld;
    t_rev_info             r5_info;
    logic [C_OFS_W-1:0]    r5_ofs;
    logic [C_DOY_W-1:0]    r5_doy;
    logic                  r5_leap;
    logic [C_YIDX_W-1:0]   n5_idx0;
    logic [C_YIDX_W-1:0]   n5_idx1;
    logic [C_DNUM_W-1:0]   n5_ys0;
    logic [C_DNUM_W-1:0]   n5_ys1;
    logic                  n5_step;
    logic [C_OFS_W-1:0]    n5_ofs;
    logic [C_DNUM_W-1:0]   n5_base;
    logic [C_DOY_W-1:0]    n5_doy;

    logic                  r6_vld;
    t_result               r6_res;
    logic [C_MONTH_W-1:0]  n6_month;
    logic [C_DOY_W-1:0]    n6_first;
    t_result               n6_res;

    // Estimate the year offset as floor(rel_day / 366), a lower bound
    assign n4_prod = C_PROD_W'(i_info.rel_day) * C_PROD_W'(C_INV366);

    // Correct the estimate by at most one year, take the day of the year
    always_comb begin
        n5_idx0 = C_YIDX_W'(r4_ofs);
        n5_idx1 = n5_idx0 + C_YIDX_W'(1);
        n5_ys0  = C_YEAR_START[n5_idx0];
        n5_ys1  = C_YEAR_START[n5_idx1];
        n5_step = (r4_info.rel_day >= n5_ys1);
        n5_ofs  = n5_step ? (r4_ofs + C_OFS_W'(1)) : r4_ofs;
        n5_base = n5_step ? n5_ys1 : n5_ys0;
        n5_doy  = C_DOY_W'(r4_info.rel_day - n5_base) + C_DOY_W'(1);
    end

    // Pick the last month that starts on or before the day of the year
    always_comb begin
        logic [C_DOY_W-1:0] thr;
        n6_month = C_MONTH_W'(1);
        n6_first = '0;
        thr      = '0;
        for (int k = 2; k <= C_DEC; k++) begin
            thr = C_MONTH_START[k] + C_DOY_W'(r5_leap && (k > C_FEB));
            if (thr < r5_doy) begin
                n6_month = C_MONTH_W'(k);
                n6_first = thr;
            end
        end
    end

    // Assemble the result, zero the new date when out of range
    always_comb begin
        n6_res.date_valid   = r5_info.date_valid;
        n6_res.day_number   = r5_info.day_number;
        n6_res.weekday      = r5_info.weekday;
        n6_res.out_of_range = r5_info.out_of_range;
        if (r5_info.out_of_range) begin
            n6_res.new_day     = '0;
            n6_res.new_month   = '0;
            n6_res.new_year    = '0;
            n6_res.new_weekday = '0;
        end else begin
            n6_res.new_day     = C_DAY_W'(r5_doy - n6_first);
            n6_res.new_month   = n6_month;
            n6_res.new_year    = C_YEAR_W'(FIRST_YEAR) + C_YEAR_W'(r5_ofs);
            n6_res.new_weekday = r5_info.new_weekday;
        end
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            r4_vld <= i_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        r4_info <= i_info;
        r4_ofs  <= n4_prod[C_INV366_SH +: C_OFS_W];
        r5_info <= r4_info;
        r5_ofs  <= n5_ofs;
        r5_doy  <= n5_doy;
        r5_leap <= C_LEAP[C_YIDX_W'(n5_ofs)];
        r6_res  <= n6_res;
    end

    assign o_vld = r6_vld;
    assign o_res = r6_res;

endmodule

/* rtl/core/date_to_day_number.sv */
// ----------------------------------------------------------------------------
// date_to_day_number
// Gregorian date to serial day number, plus a day offset converted back.
//
// Usage:
//   Drive in_day, in_month, in_year and days_to_add and raise start; the
//   item transfers on a rising edge with start high and busy low. The date
//   is checked (years 1900 to 2155); an invalid one becomes 1 Jan 1900.
//   Each result is on the o_ ports for one cycle with o_done high: valid
//   flag, serial day (1 for 1 Jan 1900), weekday (0 Sunday), the date and
//   weekday after adding days_to_add, and an out-of-range flag that zeroes
//   the new date when the sum passes 31 Dec 2155.
//   Throughput: one item per cycle through a six-stage pipeline; the
//   stages are set by the reciprocal multiplies and the year table reads.
//   Reset: busy is high during reset and the cycle after, all in-flight
//   items are dropped. The receiver cannot stall; o_done is never held.
// ----------------------------------------------------------------------------
`include "date_to_day_number_defines.svh"

module date_to_day_number (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dtdn_pkg::C_DAY_W-1:0]   i_in_day,
    input  logic [dtdn_pkg::C_MONTH_W-1:0] i_in_month,
    input  logic [dtdn_pkg::C_YEAR_W-1:0]  i_in_year,
    input  logic [dtdn_pkg::C_ADD_W-1:0]   i_days_to_add,
    output logic                          o_done,
    output logic                          o_date_valid,
    output logic [dtdn_pkg::C_DNUM_W-1:0]  o_day_number,
    output logic [dtdn_pkg::C_WDAY_W-1:0]  o_weekday,
    output logic [dtdn_pkg::C_DAY_W-1:0]   o_new_day,
    output logic [dtdn_pkg::C_MONTH_W-1:0] o_new_month,
    output logic [dtdn_pkg::C_YEAR_W-1:0]  o_new_year,
    output logic [dtdn_pkg::C_WDAY_W-1:0]  o_new_weekday,
    output logic                          o_out_of_range
);
    import dtdn_pkg::*;

    localparam int C_LATENCY = 6;
    localparam int C_Q7_W    = C_ADD_W + 17 - C_INV7_SH;

    logic                  r_busy;
    logic                  w_accept;

    // Stage 1: checked and replaced date
    logic [C_YEAR_W-1:0]   n1_year_ofs;
    logic                  n1_year_ok;
    logic                  n1_month_ok;
    logic                  n1_day_ok;
    logic                  n1_leap;
    logic [C_DAY_W-1:0]    n1_limit;
    logic                  n1_valid;
    logic [C_ADD_W+16:0]   n1_prod;
    logic                  r1_vld;
    logic                  r1_date_valid;
    logic [C_DAY_W-1:0]    r1_day;
    logic [C_MONTH_W-1:0]  r1_month;
    logic [C_OFS_W-1:0]    r1_ofs;
    logic                  r1_leap;
    logic [C_ADD_W-1:0]    r1_add;
    logic [C_Q7_W-1:0]     r1_add_q;

    // Stage 2: serial day and weekday
    logic                  n2_adj;
    logic [C_DOY_W-1:0]    n2_first;
    logic [C_DNUM_W-1:0]   n2_serial;
    logic [C_WDAY_W-1:0]   n2_wday;
    logic                  r2_vld;
    logic                  r2_date_valid;
    logic [C_DNUM_W-1:0]   r2_serial;
    logic [C_WDAY_W-1:0]   r2_wday;
    logic [C_ADD_W-1:0]    r2_add;
    logic [C_WDAY_W-1:0]   r2_add_m7;

    // Stage 3: sum, range check and new weekday
    logic [C_SUM_W-1:0]    n3_sum;
    t_rev_info             n3_info;
    logic                  r3_vld;
    t_rev_info             r3_info;

    logic                  w_res_vld;
    t_result               w_res;

    assign w_accept = start && !busy;
    assign busy     = r_busy;

    // Check the input date against the calendar and the span
    always_comb begin
        n1_year_ofs = i_in_year - C_YEAR_W'(FIRST_YEAR);
        n1_year_ok  = (i_in_year >= C_YEAR_W'(FIRST_YEAR)) &&
                      (i_in_year <= C_YEAR_W'(LAST_YEAR));
        n1_month_ok = (i_in_month != '0) && (i_in_month <= C_MONTH_W'(C_DEC));
        n1_leap     = C_LEAP[C_YIDX_W'(n1_year_ofs[C_OFS_W-1:0])];
        n1_limit    = C_MONTH_LEN[i_in_month] +
                      C_DAY_W'(n1_leap && (i_in_month == C_MONTH_W'(C_FEB)));
        n1_day_ok   = (i_in_day != '0) && (i_in_day <= n1_limit);
        n1_valid    = n1_year_ok && n1_month_ok && n1_day_ok;
    end

    // Quotient of days_to_add by 7 through the reciprocal
    assign n1_prod = (C_ADD_W + 17)'(i_days_to_add) * (C_ADD_W + 17)'(C_INV7);

    // Serial day of the checked date and its weekday
    always_comb begin
        n2_adj    = r1_leap && (r1_month > C_MONTH_W'(C_FEB));
        n2_first  = C_MONTH_START[r1_month] + C_DOY_W'(n2_adj);
        n2_serial = C_YEAR_START[C_YIDX_W'(r1_ofs)] + C_DNUM_W'(n2_first) +
                    C_DNUM_W'(r1_day);
        n2_wday   = f_mod7_small(6'(C_YEAR_MOD7[C_YIDX_W'(r1_ofs)]) +
                                 6'(C_MONTH_MOD7[r1_month]) + 6'(n2_adj) + 6'(r1_day));
    end

    // Add the offset, flag a sum past the span, rebase to zero
    always_comb begin
        n3_sum               = C_SUM_W'(r2_serial) + C_SUM_W'(r2_add);
        n3_info.date_valid   = r2_date_valid;
        n3_info.day_number   = r2_serial;
        n3_info.weekday      = r2_wday;
        n3_info.new_weekday  = f_mod7_small(6'(r2_wday) + 6'(r2_add_m7));
        n3_info.out_of_range = (n3_sum > C_SUM_W'(C_LAST_SERIAL));
        n3_info.rel_day      = C_DNUM_W'(n3_sum - C_SUM_W'(1));
    end

    // Hold busy through reset and release it in the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= w_accept;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    // Advance the payload, replacing an invalid date by 1 Jan of the first year
    always_ff @(posedge i_clk) begin
        r1_date_valid <= n1_valid;
        r1_day        <= n1_valid ? i_in_day : C_DAY_W'(1);
        r1_month      <= n1_valid ? i_in_month : C_MONTH_W'(1);
        r1_ofs        <= n1_valid ? n1_year_ofs[C_OFS_W-1:0] : '0;
        r1_leap       <= n1_valid ? n1_leap : C_LEAP[0];
        r1_add        <= i_days_to_add;
        r1_add_q      <= n1_prod[C_INV7_SH +: C_Q7_W];

        r2_date_valid <= r1_date_valid;
        r2_serial     <= n2_serial;
        r2_wday       <= n2_wday;
        r2_add        <= r1_add;
        // 7*q mod 8 is -q mod 8, so the low bits give the remainder
        r2_add_m7     <= r1_add[C_WDAY_W-1:0] + r1_add_q[C_WDAY_W-1:0];

        r3_info       <= n3_info;
    end

    dtdn_day_to_date u_day_to_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_info  (r3_info),
        .o_vld   (w_res_vld),
        .o_res   (w_res)
    );

    assign o_done         = w_res_vld;
    assign o_date_valid   = w_res.date_valid;
    assign o_day_number   = w_res.day_number;
    assign o_weekday      = w_res.weekday;
    assign o_new_day      = w_res.new_day;
    assign o_new_month    = w_res.new_month;
    assign o_new_year     = w_res.new_year;
    assign o_new_weekday  = w_res.new_weekday;
    assign o_out_of_range = w_res.out_of_range;

    // Each transfer yields exactly one result a fixed number of cycles later
    `DTDN_ASSERT_HOLDS(a_done_latency, (o_done == $past(start && !busy, C_LATENCY)), "result strobe does not match transfer latency")
    // An out-of-range sum clears the whole new date
    `DTDN_ASSERT_IMPLY(a_oor_zero, (o_done && o_out_of_range), ((o_new_day == '0) && (o_new_month == '0) && (o_new_year == '0) && (o_new_weekday == '0)), "new date not cleared when out of range")
    // An in-range sum yields a real month and day
    `DTDN_ASSERT_IMPLY(a_new_date_sane, (o_done && !o_out_of_range), ((o_new_month != '0) && (o_new_month <= C_MONTH_W'(C_DEC)) && (o_new_day != '0)), "new date outside calendar")
    // A replaced date is day one, a Monday
    `DTDN_ASSERT_IMPLY(a_default_date, (o_done && !o_date_valid), ((o_day_number == C_DNUM_W'(1)) && (o_weekday == C_WDAY_W'(1))), "invalid date not replaced by day one")

endmodule

/* sim/date_to_day_number_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_to_day_number_test
// Self-checking bench for the date to day number converter. Dates go in over
// the start/busy handshake, and a local calendar model predicts each result.
// The prediction covers the valid flag, serial day, weekday, the date after
// the added days and the out-of-range flag. Directed tests hit the calendar
// corners. A long random mix follows, with gap patterns that change along the run.
// ----------------------------------------------------------------------------
module date_to_day_number_test;
    import dtdn_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_DATES = 1750;

    // Month lengths and first day within a non-leap year
    localparam int MONTH_DAYS [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int MONTH_OFS  [13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                       304, 334};

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 start         = 1'b0;
    logic                 busy;
    logic [C_DAY_W-1:0]   i_in_day      = '0;
    logic [C_MONTH_W-1:0] i_in_month    = '0;
    logic [C_YEAR_W-1:0]  i_in_year     = '0;
    logic [C_ADD_W-1:0]   i_days_to_add = '0;
    logic                 o_done;
    logic                 o_date_valid;
    logic [C_DNUM_W-1:0]  o_day_number;
    logic [C_WDAY_W-1:0]  o_weekday;
    logic [C_DAY_W-1:0]   o_new_day;
    logic [C_MONTH_W-1:0] o_new_month;
    logic [C_YEAR_W-1:0]  o_new_year;
    logic [C_WDAY_W-1:0]  o_new_weekday;
    logic                 o_out_of_range;

    t_result pending_dates [$];
    t_result want_date;
    int      err_count    = 0;
    int      stall_cycles = 0;
    int      gap_mode     = 1;
    int      last_serial;

    date_to_day_number uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_in_day       (i_in_day),
        .i_in_month     (i_in_month),
        .i_in_year      (i_in_year),
        .i_days_to_add  (i_days_to_add),
        .o_done         (o_done),
        .o_date_valid   (o_date_valid),
        .o_day_number   (o_day_number),
        .o_weekday      (o_weekday),
        .o_new_day      (o_new_day),
        .o_new_month    (o_new_month),
        .o_new_year     (o_new_year),
        .o_new_weekday  (o_new_weekday),
        .o_out_of_range (o_out_of_range)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit leap_of(input int yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    // Days from 1 Jan of the first year up to 1 Jan of yr
    function automatic int days_to_jan1(input int yr);
        int acc;
        acc = 0;
        for (int k = FIRST_YEAR; k < yr; k++) begin
            acc += 365 + leap_of(k);
        end
        return acc;
    endfunction

    // Predict the full result for one date and day count
    function automatic t_result predict_dates(input logic [C_DAY_W-1:0] d,
                                              input logic [C_MONTH_W-1:0] m,
                                              input logic [C_YEAR_W-1:0] y,
                                              input logic [C_ADD_W-1:0] add);
        t_result r;
        int      dd;
        int      mm;
        int      yy;
        int      serial;
        int      total;
        int      rest;
        int      cur_y;
        int      cur_m;
        int      month_first;
        bit      ok;
        dd = d;
        mm = m;
        yy = y;
        ok = (yy >= FIRST_YEAR) && (yy <= LAST_YEAR) && (mm >= 1) && (mm <= 12);
        if (ok) begin
            ok = (dd >= 1) && (dd <= MONTH_DAYS[mm] + ((mm == 2 && leap_of(yy)) ? 1 : 0));
        end
        // Replace a bad date with 1 Jan of the first year
        if (!ok) begin
            dd = 1;
            mm = 1;
            yy = FIRST_YEAR;
        end
        serial = days_to_jan1(yy) + MONTH_OFS[mm] + ((mm > 2 && leap_of(yy)) ? 1 : 0) + dd;
        total  = serial + int'(add);
        r              = '0;
        r.date_valid   = ok;
        r.day_number   = C_DNUM_W'(serial);
        r.weekday      = C_WDAY_W'(serial % 7);
        if (total > days_to_jan1(LAST_YEAR + 1)) begin
            r.out_of_range = 1'b1;
        end else begin
            // Walk whole years, then step back to the containing month
            rest  = total;
            cur_y = FIRST_YEAR;
            while (cur_y < LAST_YEAR && rest > 365 + leap_of(cur_y)) begin
                rest -= 365 + leap_of(cur_y);
                cur_y++;
            end
            cur_m       = 12;
            month_first = MONTH_OFS[12] + (leap_of(cur_y) ? 1 : 0);
            while (cur_m > 1 && month_first >= rest) begin
                cur_m--;
                month_first = MONTH_OFS[cur_m] + ((cur_m > 2 && leap_of(cur_y)) ? 1 : 0);
            end
            r.new_day     = C_DAY_W'(rest - month_first);
            r.new_month   = C_MONTH_W'(cur_m);
            r.new_year    = C_YEAR_W'(cur_y);
            r.new_weekday = C_WDAY_W'(total % 7);
        end
        return r;
    endfunction

    // Send one date; hold start high into the next call when no gap follows
    task automatic send_date(input int d, input int m, input int y, input int add);
        int gap;
        case (gap_mode)
            0: gap = 0;
            1: gap = $urandom_range(0, 19);
            default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
        endcase
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_day      = C_DAY_W'(d);
        i_in_month    = C_MONTH_W'(m);
        i_in_year     = C_YEAR_W'(y);
        i_days_to_add = C_ADD_W'(add);
        start         = 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy);
        pending_dates.push_back(predict_dates(i_in_day, i_in_month, i_in_year, i_days_to_add));
        @(negedge i_clk);
    endtask

    task automatic check_field(input string label, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want_v, got_v);
            err_count++;
        end
    endtask

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_dates.size() == 0) begin
                $display("%0t: result with nothing pending, expected none, got day_number %0d",
                         $time, o_day_number);
                err_count++;
            end else begin
                want_date = pending_dates.pop_front();
                check_field("date_valid", want_date.date_valid, o_date_valid);
                check_field("day_number", want_date.day_number, o_day_number);
                check_field("weekday", want_date.weekday, o_weekday);
                check_field("new_day", want_date.new_day, o_new_day);
                check_field("new_month", want_date.new_month, o_new_month);
                check_field("new_year", want_date.new_year, o_new_year);
                check_field("new_weekday", want_date.new_weekday, o_new_weekday);
                check_field("out_of_range", want_date.out_of_range, o_out_of_range);
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transfer or result
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // First and last supported days, and the full day count
    task automatic test_span_extremes();
        send_date(1, 1, FIRST_YEAR, 0);
        send_date(1, 1, FIRST_YEAR, 65535);
        send_date(31, 12, LAST_YEAR, 0);
        send_date(31, 12, LAST_YEAR, 1);
        send_date(1, 1, LAST_YEAR, 364);
        send_date(1, 1, LAST_YEAR, 365);
        send_date(31, 12, LAST_YEAR, 65535);
    endtask

    // Leap rules: every fourth year, not centuries, but every 400th
    task automatic test_leap_days();
        send_date(29, 2, 2000, 0);
        send_date(29, 2, 1900, 0);
        send_date(29, 2, 2100, 5);
        send_date(29, 2, 2004, 366);
        send_date(28, 2, 1999, 1);
        send_date(28, 2, 2000, 1);
        send_date(31, 12, 1999, 1);
    endtask

    // Out-of-calendar fields fall back to the default date
    task automatic test_invalid_dates();
        send_date(0, 6, 2020, 10);
        send_date(31, 4, 2020, 0);
        send_date(31, 0, 2020, 1);
        send_date(15, 13, 2020, 2);
        send_date(31, 15, 4095, 65535);
        send_date(1, 1, FIRST_YEAR - 1, 3);
        send_date(1, 1, LAST_YEAR + 1, 4);
        send_date(0, 0, 0, 0);
    endtask

    // Random mix: mostly valid dates, edges of the span, February, noise
    task automatic test_random_mix();
        int      d;
        int      m;
        int      y;
        int      add;
        int      pick;
        int      serial;
        t_result probe;
        for (int n = 0; n < RANDOM_DATES; n++) begin
            // Switch the gap pattern every 50 dates
            if (n % 50 == 0) begin
                gap_mode = $urandom_range(0, 2);
            end
            pick = $urandom_range(0, 99);
            y    = $urandom_range(FIRST_YEAR, LAST_YEAR);
            m    = $urandom_range(1, 12);
            if (pick < 75) begin
                if (pick >= 55) begin
                    y = $urandom_range(LAST_YEAR - 179, LAST_YEAR);
                end else if (pick >= 45) begin
                    m = 2;
                end
                d = $urandom_range(1, MONTH_DAYS[m] + ((m == 2 && leap_of(y)) ? 1 : 0));
                if (pick >= 55) begin
                    // Land within a few days of the last supported day
                    probe  = predict_dates(C_DAY_W'(d), C_MONTH_W'(m), C_YEAR_W'(y), '0);
                    serial = probe.day_number;
                    add = last_serial - serial + $urandom_range(0, 6) - 3;
                    if (add < 0) add = 0;
                    if (add > 65535) add = 65535;
                end else if (pick % 3 == 0) begin
                    add = $urandom_range(0, 65535);
                end else begin
                    add = $urandom_range(0, 400);
                end
            end else if (pick < 85) begin
                // Month ends, sometimes one day past
                d   = MONTH_DAYS[m] + ((m == 2 && leap_of(y)) ? 1 : 0) + $urandom_range(0, 1);
                add = $urandom_range(0, 3);
            end else begin
                d   = $urandom_range(0, 31);
                m   = $urandom_range(0, 15);
                y   = $urandom_range(0, 4095);
                add = $urandom_range(0, 65535);
            end
            send_date(d, m, y, add);
        end
    endtask

    initial begin
        last_serial = days_to_jan1(LAST_YEAR + 1);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_span_extremes();
        test_leap_days();
        test_invalid_dates();
        test_random_mix();
        start = 1'b0;

        // Drain the pipeline
        while (pending_dates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
